>>> hdl/mfs_pkg.sv
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared types, codes and a helper function for the multilevel feedback
// scheduler.
// ----------------------------------------------------------------------------
package mfs_pkg;

    localparam int ID_W      = 4;
    localparam int SVC_W     = 12;
    localparam int TIME_W    = 16;
    localparam int QUANT_W   = 8;
    localparam int LVL_ARG_W = 4;
    // Widest base quantum shifted by the deepest level that is supported.
    localparam int SLICE_SHW = QUANT_W + (1 << LVL_ARG_W) - 1;

    typedef enum logic {
        OP_ADMIT = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    typedef enum logic {
        CFG_DOUBLING     = 1'b0,
        CFG_BASE_QUANTUM = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_op              op;
        logic [ID_W-1:0]  proc_id;
        logic [SVC_W-1:0] service_time;
    } t_item;

    typedef struct packed {
        logic              ran_valid;
        logic [ID_W-1:0]   ran_id;
        logic              finished;
        logic [TIME_W-1:0] finish_time;
        logic              admit_error;
    } t_result;

    // Slice length for a level; a zero base counts as one, long slices saturate.
    function automatic logic [TIME_W-1:0] slice_len(
        input logic                 doubling,
        input logic [QUANT_W-1:0]   base,
        input logic [LVL_ARG_W-1:0] lvl
    );
        logic [QUANT_W-1:0]   q;
        logic [SLICE_SHW-1:0] sh;
        q  = (base == '0) ? QUANT_W'(1) : base;
        sh = SLICE_SHW'(q) << lvl;
        if (!doubling) begin
            return TIME_W'(q);
        end
        if (|sh[SLICE_SHW-1:TIME_W]) begin
            return {TIME_W{1'b1}};
        end
        return sh[TIME_W-1:0];
    endfunction

endpackage

>>> hdl/multilevel_feedback_scheduler.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler
// Multilevel feedback queue scheduler with admit and tick items, one result
// per item.
// ----------------------------------------------------------------------------
// The block accepts one item per clock cycle while the input stall is low
// and returns exactly one result for every item, in order. An item is
// captured in an input register, then the whole scheduling decision (level
// priority encode, FIFO pop or push, remaining-time decrement, slice
// countdown) is made in one pass and written to the result register. With
// the output side never stalling, the sustained rate is one item per cycle.
// A stall on the result side holds the result register and, once the input
// register is full as well, raises the input stall. Configuration writes are
// always taken (ready is held high) and apply to items processed after the
// write; they should only be issued while no item is in flight. All queue
// storage sits in flip-flops, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler #(
    parameter int MAX_PROCS  = 16,
    parameter int NUM_LEVELS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Item input channel.
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_op,
    input  logic [mfs_pkg::ID_W-1:0]     i_proc_id,
    input  logic [mfs_pkg::SVC_W-1:0]    i_service_time,
    // Result output channel.
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_ran_valid,
    output logic [mfs_pkg::ID_W-1:0]     o_ran_id,
    output logic                         o_finished,
    output logic [mfs_pkg::TIME_W-1:0]   o_finish_time,
    output logic                         o_admit_error,
    // Configuration write channel.
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [mfs_pkg::QUANT_W-1:0]  i_cfg_data
);
    import mfs_pkg::*;

    logic               r_in_valid;
    t_item              r_in_item;
    logic               r_out_valid;
    t_result            r_out_result;
    logic               r_doubling;
    logic [QUANT_W-1:0] r_base_quantum;

    logic    out_adv;
    logic    fire;
    t_result core_result;

    // The result register can take a new value when it is empty or its
    // current result is being transferred out in this cycle.
    assign out_adv    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_adv;
    assign o_in_stall = r_in_valid && !out_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item.op           <= t_op'(i_op);
            r_in_item.proc_id      <= i_proc_id;
            r_in_item.service_time <= i_service_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_result <= core_result;
        end
    end

    // Configuration registers; doubling is on and the base slice is one tick
    // after reset.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_doubling     <= 1'b1;
            r_base_quantum <= QUANT_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_DOUBLING:     r_doubling     <= i_cfg_data[0];
                CFG_BASE_QUANTUM: r_base_quantum <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mfs_core #(
        .MAX_PROCS  (MAX_PROCS),
        .NUM_LEVELS (NUM_LEVELS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_item         (r_in_item),
        .i_doubling     (r_doubling),
        .i_base_quantum (r_base_quantum),
        .o_result       (core_result)
    );

    assign o_out_valid   = r_out_valid;
    assign o_ran_valid   = r_out_result.ran_valid;
    assign o_ran_id      = r_out_result.ran_id;
    assign o_finished    = r_out_result.finished;
    assign o_finish_time = r_out_result.finish_time;
    assign o_admit_error = r_out_result.admit_error;

endmodule

>>> hdl/mfs_level_fifo.sv
// ----------------------------------------------------------------------------
// mfs_level_fifo
// Circular FIFO of process ids for one priority level, with the head id
// always visible so that a pop and its use happen in the same cycle.
// ----------------------------------------------------------------------------
module mfs_level_fifo #(
    parameter int DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [mfs_pkg::ID_W-1:0]  i_push_id,
    input  logic                      i_pop,
    output logic [mfs_pkg::ID_W-1:0]  o_head_id,
    output logic                      o_nonempty,
    output logic                      o_full
);
    import mfs_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [ID_W-1:0]  r_mem [DEPTH];
    logic [IDX_W-1:0] r_head;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] n_head;
    logic [CNT_W-1:0] n_count;
    logic [IDX_W:0]   tail_sum;
    logic [IDX_W-1:0] tail;

    // A push lands behind the entries present before any pop of this cycle,
    // which is the same slot as after the pop.
    always_comb begin
        tail_sum = (IDX_W+1)'(r_head) + (IDX_W+1)'(r_count);
        if (tail_sum >= (IDX_W+1)'(DEPTH)) begin
            tail = IDX_W'(tail_sum - (IDX_W+1)'(DEPTH));
        end else begin
            tail = IDX_W'(tail_sum);
        end
        n_head = r_head;
        if (i_pop) begin
            n_head = (r_head == IDX_W'(DEPTH - 1)) ? '0 : r_head + IDX_W'(1);
        end
        n_count = r_count + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[tail] <= i_push_id;
        end
    end

    assign o_head_id  = r_mem[r_head];
    assign o_nonempty = (r_count != '0);
    assign o_full     = (r_count == CNT_W'(DEPTH));

endmodule

>>> hdl/mfs_core.sv
// ----------------------------------------------------------------------------
// mfs_core
// Scheduler state and the single-pass update for one admit or tick item.
// ----------------------------------------------------------------------------
module mfs_core #(
    parameter int MAX_PROCS  = 16,
    parameter int NUM_LEVELS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  mfs_pkg::t_item              i_item,
    input  logic                        i_doubling,
    input  logic [mfs_pkg::QUANT_W-1:0] i_base_quantum,
    output mfs_pkg::t_result            o_result
);
    import mfs_pkg::*;

    localparam int LVL_W = $clog2(NUM_LEVELS);
    localparam int PID_W = $clog2(MAX_PROCS);

    // Level FIFO hookup.
    logic [NUM_LEVELS-1:0] push;
    logic [NUM_LEVELS-1:0] pop;
    logic [NUM_LEVELS-1:0] nonempty;
    logic [NUM_LEVELS-1:0] full;
    logic [ID_W-1:0]       head_id [NUM_LEVELS];
    logic [ID_W-1:0]       push_id;

    // Scheduler state.
    logic [SVC_W-1:0]     r_rem [MAX_PROCS];
    logic [MAX_PROCS-1:0] r_live,    n_live;
    logic [ID_W-1:0]      r_run_id,  n_run_id;
    logic [LVL_W-1:0]     r_run_lvl, n_run_lvl;
    logic [TIME_W-1:0]    r_slice,   n_slice;
    logic                 r_busy,    n_busy;
    logic [TIME_W-1:0]    r_now,     n_now;

    logic             found;
    logic [LVL_W-1:0] pick_lvl;
    logic             run;
    logic [ID_W-1:0]  cur_id;
    logic [PID_W-1:0] cur_idx;
    logic [LVL_W-1:0] cur_lvl;
    logic [LVL_W-1:0] demote_lvl;
    logic [TIME_W-1:0] cur_slice;
    logic [TIME_W-1:0] new_slice;
    logic [SVC_W-1:0] cur_rem;
    logic [SVC_W-1:0] new_rem;
    logic [TIME_W-1:0] now_inc;
    logic [PID_W-1:0] aid_idx;
    logic             admit_bad;
    logic             rem_we;
    logic [PID_W-1:0] rem_wa;
    logic [SVC_W-1:0] rem_wd;

    for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_level
        mfs_level_fifo #(
            .DEPTH (MAX_PROCS)
        ) u_fifo (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_push     (push[g]),
            .i_push_id  (push_id),
            .i_pop      (pop[g]),
            .o_head_id  (head_id[g]),
            .o_nonempty (nonempty[g]),
            .o_full     (full[g])
        );
    end

    // Lowest non-empty level, and the process that runs this tick.
    always_comb begin
        found    = 1'b0;
        pick_lvl = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (nonempty[l]) begin
                found    = 1'b1;
                pick_lvl = LVL_W'(l);
            end
        end
        run       = r_busy || found;
        cur_id    = r_busy ? r_run_id  : head_id[pick_lvl];
        cur_lvl   = r_busy ? r_run_lvl : pick_lvl;
        cur_slice = r_busy ? r_slice
                           : slice_len(i_doubling, i_base_quantum, LVL_ARG_W'(pick_lvl));
        cur_idx   = PID_W'(cur_id);
        cur_rem   = r_rem[cur_idx];
        new_rem   = (cur_rem == '0) ? '0 : cur_rem - SVC_W'(1);
        new_slice = (cur_slice == '0) ? '0 : cur_slice - TIME_W'(1);
        now_inc   = r_now + TIME_W'(1);
        demote_lvl = (cur_lvl == LVL_W'(NUM_LEVELS - 1)) ? cur_lvl : cur_lvl + LVL_W'(1);
        aid_idx   = PID_W'(i_item.proc_id);
        admit_bad = (i_item.service_time == '0)
                 || (32'(i_item.proc_id) >= MAX_PROCS)
                 || r_live[aid_idx]
                 || full[0];
    end

    always_comb begin
        n_live    = r_live;
        n_run_id  = r_run_id;
        n_run_lvl = r_run_lvl;
        n_slice   = r_slice;
        n_busy    = r_busy;
        n_now     = r_now;
        push      = '0;
        pop       = '0;
        push_id   = (i_item.op == OP_ADMIT) ? i_item.proc_id : cur_id;
        rem_we    = 1'b0;
        rem_wa    = cur_idx;
        rem_wd    = new_rem;
        o_result  = '0;
        if (i_fire) begin
            case (i_item.op)
                OP_ADMIT: begin
                    if (admit_bad) begin
                        o_result.admit_error = 1'b1;
                    end else begin
                        push[0]         = 1'b1;
                        n_live[aid_idx] = 1'b1;
                        rem_we          = 1'b1;
                        rem_wa          = aid_idx;
                        rem_wd          = i_item.service_time;
                    end
                end
                OP_TICK: begin
                    n_now = now_inc;
                    if (run) begin
                        pop[pick_lvl]      = !r_busy;
                        o_result.ran_valid = 1'b1;
                        o_result.ran_id    = cur_id;
                        rem_we             = 1'b1;
                        n_run_id           = cur_id;
                        n_run_lvl          = cur_lvl;
                        if (new_rem == '0) begin
                            o_result.finished    = 1'b1;
                            o_result.finish_time = now_inc;
                            n_live[cur_idx]      = 1'b0;
                            n_busy               = 1'b0;
                            n_slice              = '0;
                        end else if (new_slice == '0) begin
                            // Slice used up: move one level down, last level keeps it.
                            push[demote_lvl] = 1'b1;
                            n_busy           = 1'b0;
                            n_slice          = '0;
                        end else begin
                            n_busy  = 1'b1;
                            n_slice = new_slice;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live    <= '0;
            r_run_id  <= '0;
            r_run_lvl <= '0;
            r_slice   <= '0;
            r_busy    <= 1'b0;
            r_now     <= '0;
        end else begin
            r_live    <= n_live;
            r_run_id  <= n_run_id;
            r_run_lvl <= n_run_lvl;
            r_slice   <= n_slice;
            r_busy    <= n_busy;
            r_now     <= n_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rem_we) begin
            r_rem[rem_wa] <= rem_wd;
        end
    end

    // A running slice always has time left on it.
    a_busy_slice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_slice != '0))
        else $error("running slice with no time left");

    // The running process is always marked live.
    a_busy_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_live[PID_W'(r_run_id)])
        else $error("running process not live");

    // A finish releases the processor on the next cycle.
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.finished) |=> !r_busy)
        else $error("processor still busy after a finish");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multilevel feedback scheduler testbench
// Drives admit and tick items into the scheduler under random valid and stall
// gaps and checks every result against a typed value or a cycle-free queue model.
// ----------------------------------------------------------------------------
// The run starts with a short table of hand-picked items: an idle tick right
// after reset, refused admits (zero service time, an id that is still live),
// the widest service time and alternating bit patterns in both fields. Rows
// whose outcome is obvious carry their expected result; the rest are checked
// against the model below. After that the run steps through several slice
// settings, including a zero base quantum (which must behave as one), the
// widest base quantum and both slice modes, with a burst of random items in
// each. Random ticks outnumber admits so that long jobs get demoted down to
// the last level and stay there. One long stretch runs without any idling on
// either side. Once, the result side holds off long enough for the block to
// fill and stall its input.
// ----------------------------------------------------------------------------
module testbench;

    import mfs_pkg::*;

    localparam int NPROC     = 16;
    localparam int NLEVELS   = 8;
    localparam int EXP_DEPTH = 64;

    // Result patterns that can be written down without thinking.
    localparam t_result NO_ACTIVITY = '0;
    localparam t_result REFUSED     = '{ran_valid: 1'b0, ran_id: '0, finished: 1'b0,
                                        finish_time: '0, admit_error: 1'b1};

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_op;
    logic [ID_W-1:0]     i_proc_id;
    logic [SVC_W-1:0]    i_service_time;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_ran_valid;
    logic [ID_W-1:0]     o_ran_id;
    logic                o_finished;
    logic [TIME_W-1:0]   o_finish_time;
    logic                o_admit_error;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic                i_cfg_index;
    logic [QUANT_W-1:0]  i_cfg_data;

    multilevel_feedback_scheduler #(
        .MAX_PROCS  (NPROC),
        .NUM_LEVELS (NLEVELS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_proc_id      (i_proc_id),
        .i_service_time (i_service_time),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_ran_valid    (o_ran_valid),
        .o_ran_id       (o_ran_id),
        .o_finished     (o_finished),
        .o_finish_time  (o_finish_time),
        .o_admit_error  (o_admit_error),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Scheduler model. It holds its own copy of the ready queues, the work
    // left per process and the slice settings, and is advanced once for every
    // item that the block accepts, in the order of acceptance.
    // ------------------------------------------------------------------------
    logic [ID_W-1:0]    ready_queue [NLEVELS][NPROC];
    int unsigned        rq_head [NLEVELS] = '{default: 0};
    int unsigned        rq_count [NLEVELS] = '{default: 0};
    logic [SVC_W-1:0]   work_left [NPROC];
    logic [NPROC-1:0]   live_mask = '0;
    logic [ID_W-1:0]    cur_id = '0;
    int unsigned        cur_level = 0;
    logic [TIME_W-1:0]  quantum_left = '0;
    bit                 cpu_busy = 1'b0;
    logic [TIME_W-1:0]  sched_now = '0;
    logic               doubling_on = 1'b1;
    logic [QUANT_W-1:0] base_slice = 8'd1;

    // Expected results in acceptance order, as a circular buffer.
    t_result     exp_buf [EXP_DEPTH];
    int unsigned exp_wr = 0;
    int unsigned exp_rd = 0;
    int          mismatches = 0;

    // Run control shared by the sender and the result side.
    bit quiet = 1'b0;        // no idling on either side while set
    bit holdoff_req = 1'b0;  // ask the result side for one long hold-off

    function automatic logic [TIME_W-1:0] slice_ticks(int unsigned lvl);
        int unsigned q;
        q = (base_slice == '0) ? 1 : base_slice;
        if (doubling_on) begin
            q = q << lvl;
            if (q > 65535) begin
                q = 65535;
            end
        end
        return q[TIME_W-1:0];
    endfunction

    function automatic bit enqueue(int unsigned lvl, logic [ID_W-1:0] id);
        if (rq_count[lvl] >= NPROC) begin
            return 1'b0;
        end
        ready_queue[lvl][(rq_head[lvl] + rq_count[lvl]) % NPROC] = id;
        rq_count[lvl]++;
        return 1'b1;
    endfunction

    // Works out the result of one item and moves the model state along.
    function automatic t_result schedule_step(t_op op, logic [ID_W-1:0] id,
                                              logic [SVC_W-1:0] svc);
        t_result     r;
        int unsigned next_level;
        r = '0;
        if (op == OP_ADMIT) begin
            // A refused admit leaves every piece of state untouched.
            if (svc == '0 || live_mask[id] || !enqueue(0, id)) begin
                r.admit_error = 1'b1;
                return r;
            end
            live_mask[id] = 1'b1;
            work_left[id] = svc;
            return r;
        end

        // With nothing running, the head of the lowest non-empty level starts.
        if (!cpu_busy) begin
            for (int lvl = 0; lvl < NLEVELS; lvl++) begin
                if (rq_count[lvl] != 0) begin
                    cur_id       = ready_queue[lvl][rq_head[lvl]];
                    rq_head[lvl] = (rq_head[lvl] + 1) % NPROC;
                    rq_count[lvl]--;
                    cur_level    = lvl;
                    quantum_left = slice_ticks(lvl);
                    cpu_busy     = 1'b1;
                    break;
                end
            end
        end

        // Time moves on even on an idle tick, and wraps at 16 bits.
        sched_now = sched_now + TIME_W'(1);
        if (!cpu_busy) begin
            return r;
        end

        r.ran_valid = 1'b1;
        r.ran_id    = cur_id;
        if (work_left[cur_id] != '0) begin
            work_left[cur_id]--;
        end
        if (quantum_left != '0) begin
            quantum_left--;
        end

        if (work_left[cur_id] == '0) begin
            r.finished      = 1'b1;
            r.finish_time   = sched_now;
            live_mask[cur_id] = 1'b0;
            cpu_busy        = 1'b0;
            quantum_left    = '0;
        end else if (quantum_left == '0) begin
            // Slice used up: demote by one level, the last level holds on.
            next_level = (cur_level + 1 >= NLEVELS) ? NLEVELS - 1 : cur_level + 1;
            void'(enqueue(next_level, cur_id));
            cpu_busy = 1'b0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Directed items. Rows marked as typed carry their own expected result.
    // ------------------------------------------------------------------------
    typedef struct packed {
        t_op              op;
        logic [ID_W-1:0]  id;
        logic [SVC_W-1:0] svc;
        logic             typed;
        t_result          want;
    } t_stim_row;

    t_stim_row dir_table [0:23] = '{
        '{OP_TICK,  4'd0,  12'd0,    1'b1, NO_ACTIVITY},  // nothing to run yet
        '{OP_ADMIT, 4'd0,  12'd0,    1'b1, REFUSED},      // zero service time
        '{OP_ADMIT, 4'd15, 12'd4095, 1'b1, NO_ACTIVITY},  // longest job, top id
        '{OP_ADMIT, 4'd15, 12'd7,    1'b1, REFUSED},      // id already live
        '{OP_ADMIT, 4'd0,  12'd1,    1'b1, NO_ACTIVITY},
        '{OP_TICK,  4'd0,  12'd0,    1'b0, NO_ACTIVITY},
        '{OP_TICK,  4'd0,  12'd0,    1'b0, NO_ACTIVITY},
        '{OP_ADMIT, 4'd0,  12'd4095, 1'b0, NO_ACTIVITY},  // id reused after finish
        '{OP_ADMIT, 4'd10, 12'd2730, 1'b0, NO_ACTIVITY},
        '{OP_ADMIT, 4'd5,  12'd1365, 1'b0, NO_ACTIVITY},
        '{OP_ADMIT, 4'd0,  12'd3,    1'b1, REFUSED},      // queued id is live too
        '{OP_TICK,  4'd0,  12'd0,    1'b0, NO_ACTIVITY},
        '{OP_TICK,  4'd0,  12'd0,    1'b0, NO_ACTIVITY},
        '{OP_TICK,  4'd0,  12'd0,    1'b0, NO_ACTIVITY},
        '{OP_TICK,  4'd0,  12'd0,    1'b0, NO_ACTIVITY},
        '{OP_TICK,  4'd0,  12'd0,    1'b0, NO_ACTIVITY},
        '{OP_TICK,  4'd0,  12'd0,    1'b0, NO_ACTIVITY},
        '{OP_TICK,  4'd0,  12'd0,    1'b0, NO_ACTIVITY},
        '{OP_TICK,  4'd0,  12'd0,    1'b0, NO_ACTIVITY},
        '{OP_TICK,  4'd0,  12'd0,    1'b0, NO_ACTIVITY},
        '{OP_ADMIT, 4'd3,  12'd1,    1'b0, NO_ACTIVITY},
        '{OP_TICK,  4'd0,  12'd0,    1'b0, NO_ACTIVITY},
        '{OP_TICK,  4'd0,  12'd0,    1'b0, NO_ACTIVITY},
        '{OP_TICK,  4'd0,  12'd0,    1'b0, NO_ACTIVITY}
    };

    // ------------------------------------------------------------------------
    // Sender side. Valid is raised at a rising edge and the item is taken at
    // the first later edge with the stall low; an item that follows directly
    // keeps valid high, so valid only ever gets one assignment per edge.
    // ------------------------------------------------------------------------
    task automatic offer_item(t_op op, logic [ID_W-1:0] id, logic [SVC_W-1:0] svc,
                              logic typed, t_result want);
        t_result predicted;
        while (!quiet && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_proc_id      <= id;
        i_service_time <= svc;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predicted = schedule_step(op, id, svc);
        exp_buf[exp_wr % EXP_DEPTH] = typed ? want : predicted;
        exp_wr++;
    endtask

    // Random item: mostly ticks, so that jobs sink through the levels. Most
    // admits name a free id; the rest use a random id that may be live, so that
    // some are refused, which the block must flag without touching its queues.
    task automatic offer_random_item(int admit_pct);
        t_op              op;
        logic [ID_W-1:0]  id;
        logic [SVC_W-1:0] svc;
        int               p;
        int               start;
        op  = ($urandom_range(99) < admit_pct) ? OP_ADMIT : OP_TICK;
        id  = ID_W'($urandom_range(NPROC - 1));
        svc = SVC_W'($urandom_range(4095));
        if (op == OP_ADMIT) begin
            if ($urandom_range(3) != 0) begin
                start = int'(id);
                for (int k = 0; k < NPROC; k++) begin
                    if (!live_mask[(start + k) % NPROC]) begin
                        id = ID_W'((start + k) % NPROC);
                        break;
                    end
                end
            end
            p = $urandom_range(99);
            if (p < 4) begin
                svc = '0;
            end else if (p < 10) begin
                svc = 12'd4095;
            end else if (p < 55) begin
                svc = SVC_W'($urandom_range(40, 1));
            end else begin
                svc = SVC_W'($urandom_range(700, 1));
            end
        end
        offer_item(op, id, svc, 1'b0, NO_ACTIVITY);
    endtask

    // The sender goes quiet until every result is back. Each item yields one
    // result, so the block is idle then.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (exp_wr != exp_rd) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Both registers in back-to-back transfers; valid stays high in between.
    task automatic apply_setting(logic dbl, logic [QUANT_W-1:0] base);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_DOUBLING;
        i_cfg_data  <= {{(QUANT_W-1){1'b0}}, dbl};
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        doubling_on = dbl;
        i_cfg_index <= CFG_BASE_QUANTUM;
        i_cfg_data  <= base;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        base_slice = base;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: checks each transfer against the oldest expectation, then
    // picks the stall for the next cycle. The stall is read before it is
    // assigned, so the check sees the value that was in force at the edge.
    // ------------------------------------------------------------------------
    initial begin
        t_result want;
        int      hold_left;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (exp_wr == exp_rd) begin
                    $error("result transfer with no item outstanding");
                    mismatches++;
                end else begin
                    want = exp_buf[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (o_ran_valid !== want.ran_valid) begin
                        $error("ran_valid: expected %0d, got %0d", want.ran_valid, o_ran_valid);
                        mismatches++;
                    end
                    if (o_ran_id !== want.ran_id) begin
                        $error("ran_id: expected %0d, got %0d", want.ran_id, o_ran_id);
                        mismatches++;
                    end
                    if (o_finished !== want.finished) begin
                        $error("finished: expected %0d, got %0d", want.finished, o_finished);
                        mismatches++;
                    end
                    if (o_finish_time !== want.finish_time) begin
                        $error("finish_time: expected %0d, got %0d",
                               want.finish_time, o_finish_time);
                        mismatches++;
                    end
                    if (o_admit_error !== want.admit_error) begin
                        $error("admit_error: expected %0d, got %0d",
                               want.admit_error, o_admit_error);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (holdoff_req) begin
                // Long enough for both internal registers to fill up.
                holdoff_req = 1'b0;
                hold_left   = 80;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !quiet && ($urandom_range(99) < 26);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    logic              dbl_list  [7] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    logic [QUANT_W-1:0] base_list [7] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd1, 8'd1, 8'd0};

    initial begin
        logic [QUANT_W-1:0] base;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_op           <= OP_TICK;
        i_proc_id      <= '0;
        i_service_time <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= CFG_DOUBLING;
        i_cfg_data     <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows run with the reset settings: doubling on, base of one.
        foreach (dir_table[k]) begin
            offer_item(dir_table[k].op, dir_table[k].id, dir_table[k].svc,
                       dir_table[k].typed, dir_table[k].want);
        end
        drain();

        // One phase per slice setting. A zero base must act as a base of one;
        // the last setting uses a random base in between.
        for (int k = 0; k < 7; k++) begin
            base = (k == 6) ? QUANT_W'($urandom_range(254, 2)) : base_list[k];
            apply_setting(dbl_list[k], base);
            if (k == 1) begin
                holdoff_req = 1'b1;
            end
            repeat (150) offer_random_item(30);
            drain();
        end

        // A long stretch with no idling on either side.
        quiet = 1'b1;
        repeat (120) offer_random_item(20);
        quiet = 1'b0;
        drain();

        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // The time limit leaves a wide margin over a correct run.
    initial begin
        #1_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

>>> multilevel_feedback_scheduler.f
hdl/mfs_pkg.sv
hdl/mfs_level_fifo.sv
hdl/mfs_core.sv
hdl/multilevel_feedback_scheduler.sv
tb/testbench.sv
